@@ design/orle_pkg.sv @@
// shared types, sizes and codes for the ordered record list engine
// no dependencies; imported by orle_store, ordered_record_list_engine and the testbench
package orle_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam logic [2:0] ACT_APPEND   = 3'd0;
    localparam logic [2:0] ACT_INSERT   = 3'd1;
    localparam logic [2:0] ACT_DELETE   = 3'd2;
    localparam logic [2:0] ACT_DEL_NAME = 3'd3;
    localparam logic [2:0] ACT_UPD_NAME = 3'd4;
    localparam logic [2:0] ACT_DUMP     = 3'd5;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_FULL     = 3'd1;
    localparam logic [2:0] ST_BADPOS   = 3'd2;
    localparam logic [2:0] ST_NOTFOUND = 3'd3;
    localparam logic [2:0] ST_EMPTY    = 3'd4;

    typedef struct packed {
        logic [2:0]  action;
        logic [4:0]  position;
        logic [63:0] name_low;
        logic [7:0]  name_high;
        logic [63:0] phone_low;
        logic [15:0] phone_high;
    } item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [4:0]  entry_position;
        logic [63:0] out_name_low;
        logic [7:0]  out_name_high;
        logic [63:0] out_phone_low;
        logic [15:0] out_phone_high;
        logic [4:0]  record_count;
        logic        last;
    } result_t;

    typedef struct packed {
        logic [63:0] name_low;
        logic [7:0]  name_high;
        logic [63:0] phone_low;
        logic [15:0] phone_high;
    } record_t;

endpackage

@@ design/orle_store.sv @@
// record memory: one write port, one read port with registered read data
// depends on orle_pkg for the record type and the depth
module orle_store (
    input  logic                              clk,
    input  logic                              wr_en,
    input  logic [orle_pkg::IDX_W-1:0]        wr_addr,
    input  orle_pkg::record_t                 wr_data,
    input  logic                              rd_en,
    input  logic [orle_pkg::IDX_W-1:0]        rd_addr,
    output orle_pkg::record_t                 rd_data
);
    import orle_pkg::*;

    record_t mem [CAPACITY];
    record_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ design/ordered_record_list_engine.sv @@
// ordered record list engine: top level with the action sequencer and result register
// depends on orle_pkg and orle_store
//
// Usage: an item on the item channel (valid/ready) carries one action on an ordered
// list of up to CAPACITY records (name 72 bits, phone 80 bits). Results leave on the
// result channel (valid/ready). Every action gives one result with last set, except
// dump on a non-empty list, which gives one result per stored record (last on the
// final one), and action codes 6 and 7, which give none.
// item_ready is high only while the sequencer is idle; one item is handled at a time.
// Every step of a move or search is a memory read followed by a write or compare,
// since the store has one read and one write port.
// A result sits in an output register; the sequencer only waits on the receiver
// when it has a new result to place while the previous one is still held, so a
// stalled receiver pauses a dump record by record without losing any.
// Reset empties the list at once (count to zero); stored records are not cleared.
module ordered_record_list_engine (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  orle_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_ready,
    output orle_pkg::result_t result
);
    import orle_pkg::*;

    localparam int PW = ((CNT_W > 5) ? CNT_W : 5) + 1;

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_UP        = 4'd1;
    localparam logic [3:0] S_UP_WR     = 4'd2;
    localparam logic [3:0] S_DOWN      = 4'd3;
    localparam logic [3:0] S_DOWN_WR   = 4'd4;
    localparam logic [3:0] S_FIND_RD   = 4'd5;
    localparam logic [3:0] S_FIND_CMP  = 4'd6;
    localparam logic [3:0] S_DUMP_RD   = 4'd7;
    localparam logic [3:0] S_DUMP_WAIT = 4'd8;
    localparam logic [3:0] S_EMIT      = 4'd9;

    logic [3:0]       state_reg, state_next;
    logic [2:0]       op_reg, op_next;
    logic [2:0]       status_reg, status_next;
    logic [CNT_W-1:0] ptr_reg, ptr_next;
    logic [CNT_W-1:0] tgt_reg, tgt_next;
    logic [CNT_W-1:0] count_reg, count_next;
    record_t          item_reg, item_next;
    result_t          result_reg, result_next;
    logic             result_valid_reg, result_valid_next;

    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    record_t          wr_data;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    record_t          rd_data;

    record_t          rec_in;
    logic [PW-1:0]    pos_ext;
    logic [PW-1:0]    cnt_ext;
    logic [CNT_W-1:0] ptr_inc;
    logic [CNT_W-1:0] ptr_dec;
    logic             is_full;
    logic             ins_bad;
    logic             del_bad;
    logic             name_hit;
    logic             out_free;
    logic             dump_last;

    orle_store u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign rec_in = '{name_low:   item.name_low,
                      name_high:  item.name_high,
                      phone_low:  item.phone_low,
                      phone_high: item.phone_high};

    assign pos_ext   = PW'(item.position);
    assign cnt_ext   = PW'(count_reg);
    assign is_full   = (count_reg == CNT_W'(CAPACITY));
    assign ins_bad   = (pos_ext == '0) || (pos_ext > cnt_ext + PW'(1));
    assign del_bad   = (pos_ext == '0) || (pos_ext > cnt_ext);
    assign ptr_inc   = ptr_reg + CNT_W'(1);
    assign ptr_dec   = ptr_reg - CNT_W'(1);
    // the one shared compare: stored name against the requested name
    assign name_hit  = (rd_data.name_low == item_reg.name_low) &&
                       (rd_data.name_high == item_reg.name_high);
    assign out_free  = !result_valid_reg || result_ready;
    assign dump_last = (ptr_inc == count_reg);

    always_comb
    begin
        state_next        = state_reg;
        op_next           = op_reg;
        status_next       = status_reg;
        ptr_next          = ptr_reg;
        tgt_next          = tgt_reg;
        count_next        = count_reg;
        item_next         = item_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg;
        wr_en             = 1'b0;
        wr_addr           = ptr_reg[IDX_W-1:0];
        wr_data           = item_reg;
        rd_en             = 1'b0;
        rd_addr           = ptr_reg[IDX_W-1:0];

        if (result_valid_reg && result_ready)
        begin
            result_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    op_next   = item.action;
                    item_next = rec_in;
                    case (item.action)
                        ACT_APPEND:
                        begin
                            state_next = S_EMIT;
                            if (is_full)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                wr_en       = 1'b1;
                                wr_addr     = count_reg[IDX_W-1:0];
                                wr_data     = rec_in;
                                count_next  = count_reg + CNT_W'(1);
                                status_next = ST_OK;
                            end
                        end
                        ACT_INSERT:
                        begin
                            if (is_full)
                            begin
                                status_next = ST_FULL;
                                state_next  = S_EMIT;
                            end
                            else if (ins_bad)
                            begin
                                status_next = ST_BADPOS;
                                state_next  = S_EMIT;
                            end
                            else
                            begin
                                ptr_next   = count_reg;
                                tgt_next   = CNT_W'(pos_ext - PW'(1));
                                state_next = S_UP;
                            end
                        end
                        ACT_DELETE:
                        begin
                            if (del_bad)
                            begin
                                status_next = ST_BADPOS;
                                state_next  = S_EMIT;
                            end
                            else
                            begin
                                ptr_next   = CNT_W'(pos_ext - PW'(1));
                                state_next = S_DOWN;
                            end
                        end
                        ACT_DEL_NAME, ACT_UPD_NAME:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = ST_NOTFOUND;
                                state_next  = S_EMIT;
                            end
                            else
                            begin
                                ptr_next   = '0;
                                state_next = S_FIND_RD;
                            end
                        end
                        ACT_DUMP:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                                state_next  = S_EMIT;
                            end
                            else
                            begin
                                ptr_next   = '0;
                                state_next = S_DUMP_RD;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            // make room: move entries up one slot, top first
            S_UP:
            begin
                if (ptr_reg == tgt_reg)
                begin
                    wr_en       = 1'b1;
                    count_next  = count_reg + CNT_W'(1);
                    status_next = ST_OK;
                    state_next  = S_EMIT;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = ptr_dec[IDX_W-1:0];
                    state_next = S_UP_WR;
                end
            end
            S_UP_WR:
            begin
                wr_en      = 1'b1;
                wr_data    = rd_data;
                ptr_next   = ptr_dec;
                state_next = S_UP;
            end
            // close the gap: move entries down one slot, bottom first
            S_DOWN:
            begin
                if (ptr_inc == count_reg)
                begin
                    count_next  = count_reg - CNT_W'(1);
                    status_next = ST_OK;
                    state_next  = S_EMIT;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = ptr_inc[IDX_W-1:0];
                    state_next = S_DOWN_WR;
                end
            end
            S_DOWN_WR:
            begin
                wr_en      = 1'b1;
                wr_data    = rd_data;
                ptr_next   = ptr_inc;
                state_next = S_DOWN;
            end
            S_FIND_RD:
            begin
                rd_en      = 1'b1;
                state_next = S_FIND_CMP;
            end
            S_FIND_CMP:
            begin
                if (name_hit)
                begin
                    if (op_reg == ACT_DEL_NAME)
                    begin
                        state_next = S_DOWN;
                    end
                    else
                    begin
                        wr_en       = 1'b1;
                        status_next = ST_OK;
                        state_next  = S_EMIT;
                    end
                end
                else if (ptr_inc == count_reg)
                begin
                    status_next = ST_NOTFOUND;
                    state_next  = S_EMIT;
                end
                else
                begin
                    ptr_next   = ptr_inc;
                    state_next = S_FIND_RD;
                end
            end
            S_DUMP_RD:
            begin
                rd_en      = 1'b1;
                state_next = S_DUMP_WAIT;
            end
            S_DUMP_WAIT:
            begin
                if (out_free)
                begin
                    result_valid_next = 1'b1;
                    result_next = '{status:         ST_OK,
                                    entry_position: 5'(ptr_inc),
                                    out_name_low:   rd_data.name_low,
                                    out_name_high:  rd_data.name_high,
                                    out_phone_low:  rd_data.phone_low,
                                    out_phone_high: rd_data.phone_high,
                                    record_count:   5'(count_reg),
                                    last:           dump_last};
                    ptr_next   = ptr_inc;
                    state_next = dump_last ? S_IDLE : S_DUMP_RD;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    result_valid_next = 1'b1;
                    result_next = '{status:         status_reg,
                                    entry_position: 5'd0,
                                    out_name_low:   64'd0,
                                    out_name_high:  8'd0,
                                    out_phone_low:  64'd0,
                                    out_phone_high: 16'd0,
                                    record_count:   5'(count_reg),
                                    last:           1'b1};
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            op_reg           <= ACT_APPEND;
            status_reg       <= ST_OK;
            ptr_reg          <= '0;
            tgt_reg          <= '0;
            count_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            op_reg           <= op_next;
            status_reg       <= status_next;
            ptr_reg          <= ptr_next;
            tgt_reg          <= tgt_next;
            count_reg        <= count_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        result_reg <= result_next;
    end

    // no item is taken while reset is held
    assign item_ready   = rst_n && (state_reg == S_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // list never grows past its capacity
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("record count beyond capacity");

    // the walking pointer never passes the end of the list
    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        ptr_reg <= count_reg)
        else $error("pointer past end of list");

    // one action adds or removes at most one record
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == $past(count_reg)) ||
        (count_reg == $past(count_reg) + CNT_W'(1)) ||
        (count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("record count jumped");

    // only a dump gives results that are not the last of their item
    a_not_last_ok: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.last |-> result.status == ST_OK &&
        result.entry_position != 5'd0)
        else $error("intermediate result outside a dump");

    // a dump never changes the count
    a_count_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DUMP_WAIT |=> count_reg == $past(count_reg))
        else $error("count changed during dump");

endmodule

@@ tb/ordered_record_list_engine_tb.sv @@
`timescale 1ns / 1ps
// self-checking testbench for the ordered record list engine: directed and random items
// depends on orle_pkg and ordered_record_list_engine
module ordered_record_list_engine_tb;
    import orle_pkg::*;

    localparam logic [2:0] ACT_SPARE_LO = 3'd6;
    localparam logic [2:0] ACT_SPARE_HI = 3'd7;
    localparam int RANDOM_ITEMS = 96;
    localparam int DRAIN_CYCLES = 64;
    localparam int CYCLE_LIMIT  = 400000;

    localparam logic [63:0] NAME_A_LOW  = 64'h0000_006e_6f73_7261;
    localparam logic [63:0] NAME_B_LOW  = 64'h7265_6b61_6d6c_6f6f;
    localparam logic [7:0]  NAME_B_HIGH = 8'h73;

    logic    clk;
    logic    rst_n = 1'b0;
    logic    item_valid = 1'b0;
    logic    item_ready;
    item_t   item = '0;
    logic    result_valid;
    logic    result_ready = 1'b0;
    result_t result;

    item_t   queued_requests[$];
    result_t expected_replies[$];
    record_t directory[CAPACITY];
    int      directory_count = 0;
    bit      grow_phase = 1'b1;
    bit      item_took = 1'b0;
    int      send_gap = 0;
    int      stall_left = 0;
    int      items_queued = 0;
    int      items_taken = 0;
    int      mismatch_count = 0;
    int      cycle_count = 0;

    ordered_record_list_engine u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
    end

    task automatic report(input string msg);
        $display("mismatch: %s", msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string fname, input logic [79:0] got,
                               input logic [79:0] want);
        if (got !== want)
            report($sformatf("%s got %h, expected %h", fname, got, want));
    endtask

    // mostly no gap, some short ones, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    task automatic drop_entry(input int idx);
        int i;
        for (i = idx; i + 1 < directory_count; i++)
            directory[i] = directory[i + 1];
        directory_count--;
    endtask

    // applies one accepted item to the directory and queues the replies it causes
    task automatic update_directory(input item_t req);
        record_t rec;
        result_t rsp;
        int      hit;
        int      i;
        rec.name_low   = req.name_low;
        rec.name_high  = req.name_high;
        rec.phone_low  = req.phone_low;
        rec.phone_high = req.phone_high;
        rsp = '0;
        rsp.status = ST_OK;
        rsp.last = 1'b1;
        hit = -1;
        for (i = 0; i < directory_count; i++)
            if (hit < 0 && directory[i].name_low == req.name_low
                    && directory[i].name_high == req.name_high)
                hit = i;
        case (req.action)
            ACT_APPEND:
                if (directory_count >= CAPACITY)
                    rsp.status = ST_FULL;
                else
                begin
                    directory[directory_count] = rec;
                    directory_count++;
                end
            ACT_INSERT:
                if (directory_count >= CAPACITY)
                    rsp.status = ST_FULL;
                else if (req.position < 1 || int'(req.position) > directory_count + 1)
                    rsp.status = ST_BADPOS;
                else
                begin
                    for (i = directory_count; i > int'(req.position) - 1; i--)
                        directory[i] = directory[i - 1];
                    directory[req.position - 1] = rec;
                    directory_count++;
                end
            ACT_DELETE:
                if (req.position < 1 || int'(req.position) > directory_count)
                    rsp.status = ST_BADPOS;
                else
                    drop_entry(int'(req.position) - 1);
            ACT_DEL_NAME:
                if (hit < 0)
                    rsp.status = ST_NOTFOUND;
                else
                    drop_entry(hit);
            ACT_UPD_NAME:
                if (hit < 0)
                    rsp.status = ST_NOTFOUND;
                else
                    directory[hit] = rec;
            ACT_DUMP:
                if (directory_count == 0)
                    rsp.status = ST_EMPTY;
                else
                begin
                    for (i = 0; i < directory_count; i++)
                    begin
                        rsp = '0;
                        rsp.status         = ST_OK;
                        rsp.entry_position = 5'(i + 1);
                        rsp.out_name_low   = directory[i].name_low;
                        rsp.out_name_high  = directory[i].name_high;
                        rsp.out_phone_low  = directory[i].phone_low;
                        rsp.out_phone_high = directory[i].phone_high;
                        rsp.record_count   = 5'(directory_count);
                        rsp.last           = (i == directory_count - 1);
                        expected_replies.push_back(rsp);
                    end
                    return;
                end
            default:
                return;
        endcase
        rsp.record_count = 5'(directory_count);
        expected_replies.push_back(rsp);
    endtask

    function automatic item_t build_request(input logic [2:0] act, input logic [4:0] pos,
                                            input logic [63:0] nl, input logic [7:0] nh,
                                            input logic [63:0] pl, input logic [15:0] ph);
        item_t req;
        req.action     = act;
        req.position   = pos;
        req.name_low   = nl;
        req.name_high  = nh;
        req.phone_low  = pl;
        req.phone_high = ph;
        return req;
    endfunction

    task automatic queue_request(input item_t req);
        queued_requests.push_back(req);
        items_queued++;
    endtask

    // grows the list towards full, then shrinks it towards empty, with some noise
    task automatic make_request(output item_t req);
        int          r;
        int          pick;
        logic [71:0] nm;
        req.name_low   = {$urandom, $urandom};
        req.name_high  = 8'($urandom);
        req.phone_low  = {$urandom, $urandom};
        req.phone_high = 16'($urandom);
        req.position   = 5'($urandom);
        req.action     = ACT_DUMP;
        if (grow_phase && directory_count >= CAPACITY && $urandom_range(0, 1))
            grow_phase = 1'b0;
        else if (!grow_phase && directory_count == 0 && $urandom_range(0, 1))
            grow_phase = 1'b1;
        r = $urandom_range(0, 99);
        if (r < 10)
            req.action = ACT_DUMP;
        else if (r < 15)
            req.action = 3'($urandom);
        else if (grow_phase)
        begin
            if (r < 60)
                req.action = ACT_APPEND;
            else if (r < 88)
            begin
                req.action = ACT_INSERT;
                if ($urandom_range(0, 9) != 0)
                    req.position = 5'($urandom_range(1, directory_count + 1));
            end
            else
                req.action = ACT_UPD_NAME;
        end
        else
        begin
            if (r < 55)
            begin
                req.action = ACT_DELETE;
                if ($urandom_range(0, 9) != 0 && directory_count > 0)
                    req.position = 5'($urandom_range(1, directory_count));
            end
            else if (r < 88)
                req.action = ACT_DEL_NAME;
            else
                req.action = ACT_UPD_NAME;
        end
        // name searches mostly hit a stored name; new records now and then repeat one
        if (directory_count > 0 && $urandom_range(0, 99) <
                ((req.action == ACT_DEL_NAME || req.action == ACT_UPD_NAME) ? 85 : 15))
        begin
            pick = $urandom_range(0, directory_count - 1);
            nm = {directory[pick].name_low, directory[pick].name_high};
            if ($urandom_range(0, 9) == 0)
                nm[$urandom_range(0, 71)] ^= 1'b1;
            {req.name_low, req.name_high} = nm;
        end
    endtask

    // item driver
    always @(negedge clk)
    begin
        if (rst_n && !(item_valid && !item_took))
        begin
            if (send_gap != 0)
            begin
                send_gap--;
                item_valid <= 1'b0;
            end
            else if (queued_requests.size() != 0)
            begin
                item <= queued_requests.pop_front();
                item_valid <= 1'b1;
                send_gap = pick_gap();
            end
            else
                item_valid <= 1'b0;
        end
    end

    // result receiver stalls
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (stall_left != 0)
            begin
                stall_left--;
                result_ready <= 1'b0;
            end
            else
            begin
                result_ready <= 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin : monitor
        result_t got;
        result_t want;
        item_took = item_valid && item_ready;
        if (item_took)
        begin
            update_directory(item);
            items_taken++;
        end
        if (rst_n && result_valid && result_ready)
        begin
            got = result;
            if (expected_replies.size() == 0)
                report($sformatf("result with nothing pending: %h", got));
            else
            begin
                want = expected_replies.pop_front();
                check_field("status", 80'(got.status), 80'(want.status));
                check_field("entry_position", 80'(got.entry_position),
                            80'(want.entry_position));
                check_field("out_name_low", 80'(got.out_name_low), 80'(want.out_name_low));
                check_field("out_name_high", 80'(got.out_name_high),
                            80'(want.out_name_high));
                check_field("out_phone_low", 80'(got.out_phone_low),
                            80'(want.out_phone_low));
                check_field("out_phone_high", 80'(got.out_phone_high),
                            80'(want.out_phone_high));
                check_field("record_count", 80'(got.record_count), 80'(want.record_count));
                check_field("last", 80'(got.last), 80'(want.last));
            end
        end
    end

    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("ordered_record_list_engine test failed");
        $finish;
    end

    initial
    begin : stimulus
        item_t req;
        int    counted;
        counted = 0;
        // empty list
        queue_request(build_request(ACT_DUMP, 5'd0, '0, '0, '0, '0));
        queue_request(build_request(ACT_DELETE, 5'd1, '0, '0, '0, '0));
        queue_request(build_request(ACT_DEL_NAME, 5'd0, '1, '1, '0, '0));
        queue_request(build_request(ACT_UPD_NAME, 5'd0, '0, '0, '1, '1));
        queue_request(build_request(ACT_INSERT, 5'd0, '1, '1, '1, '1));
        queue_request(build_request(ACT_INSERT, 5'd2, '1, '1, '1, '1));
        // first records, all ones and all zeros
        queue_request(build_request(ACT_INSERT, 5'd1, '1, '1, '1, '1));
        queue_request(build_request(ACT_APPEND, 5'd31, '0, '0, '0, '0));
        queue_request(build_request(ACT_SPARE_LO, 5'd1, NAME_A_LOW, '0, '0, '0));
        queue_request(build_request(ACT_SPARE_HI, 5'd31, '1, '1, '1, '1));
        // insert in the middle and at the end, then past the end
        queue_request(build_request(ACT_INSERT, 5'd2, NAME_A_LOW, '0,
                                    64'h3534_3332_3130_3938, 16'h3736));
        queue_request(build_request(ACT_INSERT, 5'd4, NAME_B_LOW, NAME_B_HIGH,
                                    64'h0000_3131_3232_3333, 16'h0000));
        queue_request(build_request(ACT_INSERT, 5'd31, NAME_B_LOW, '0, '0, '0));
        // duplicate name: the update and the delete take the first one
        queue_request(build_request(ACT_APPEND, 5'd0, NAME_A_LOW, '0,
                                    64'h0102_0304_0506_0708, 16'h090a));
        queue_request(build_request(ACT_UPD_NAME, 5'd0, NAME_A_LOW, '0,
                                    64'hfedc_ba98_7654_3210, 16'h8001));
        queue_request(build_request(ACT_DEL_NAME, 5'd0, NAME_A_LOW, 8'h01, '0, '0));
        queue_request(build_request(ACT_DUMP, 5'd31, '1, '1, '1, '1));
        queue_request(build_request(ACT_DEL_NAME, 5'd0, NAME_A_LOW, '0, '1, '1));
        queue_request(build_request(ACT_DEL_NAME, 5'd0, '0, '0, '1, '1));
        queue_request(build_request(ACT_DELETE, 5'd5, '0, '0, '0, '0));
        queue_request(build_request(ACT_DELETE, 5'd0, '0, '0, '0, '0));
        queue_request(build_request(ACT_DELETE, 5'd3, '0, '0, '0, '0));
        queue_request(build_request(ACT_DELETE, 5'd1, '0, '0, '0, '0));
        queue_request(build_request(ACT_DUMP, 5'd0, '0, '0, '0, '0));

        // random part, generated from the list contents once the queue runs dry
        while (counted < RANDOM_ITEMS)
        begin
            while (queued_requests.size() != 0)
            begin
                @(posedge clk);
                #1;
            end
            make_request(req);
            queue_request(req);
            if (req.action <= ACT_DUMP)
                counted++;
        end

        while (items_taken != items_queued)
            @(posedge clk);
        while (expected_replies.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("ordered_record_list_engine test passed");
        else
            $display("ordered_record_list_engine test failed");
        $finish;
    end

endmodule
